// ===== rtl/pfde_pkg.sv =====
// Package for the Playfair digraph encryptor: key square geometry, letter and
// request types, and the per-letter location record. No dependencies.
`default_nettype none

package pfde_pkg;

  localparam int SIDE       = 5;
  localparam int LETTER_W   = 5;
  localparam int POS_W      = $clog2(SIDE);
  localparam int ROW_W      = SIDE * LETTER_W;
  localparam int CFG_IDX_W  = $clog2(SIDE);

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [POS_W-1:0]    pos_t;

  // Column c of a row sits in bits [5c+4:5c], matching element c here.
  typedef logic [SIDE-1:0][LETTER_W-1:0] row_t;
  typedef row_t [SIDE-1:0]               square_t;

  typedef struct packed {
    logic found;
    pos_t row;
    pos_t col;
  } loc_t;

  typedef struct packed {
    letter_t first_letter;
    letter_t second_letter;
  } in_t;

  typedef struct packed {
    letter_t cipher_first;
    letter_t cipher_second;
    logic    letter_missing;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/pfde_locate.sv =====
// Finds the row and column of one letter code in the key square.
// Depends on pfde_pkg.
`default_nettype none

module pfde_locate (
  input  var pfde_pkg::square_t square,
  input  var pfde_pkg::letter_t letter,
  output pfde_pkg::loc_t        loc
);

  // The last match in row-major order wins when a code appears twice.
  always_comb begin
    loc = '0;
    for (int r = 0; r < pfde_pkg::SIDE; r++) begin
      for (int c = 0; c < pfde_pkg::SIDE; c++) begin
        if (square[r][c] == letter) begin
          loc.found = 1'b1;
          loc.row   = pfde_pkg::POS_W'(r);
          loc.col   = pfde_pkg::POS_W'(c);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pfde_substitute.sv =====
// Applies the row, column and rectangle rules to two located letters.
// Depends on pfde_pkg.
`default_nettype none

module pfde_substitute (
  input  var pfde_pkg::square_t square,
  input  var pfde_pkg::loc_t    loc_a,
  input  var pfde_pkg::loc_t    loc_b,
  output pfde_pkg::out_t        result
);

  localparam pfde_pkg::pos_t LAST = pfde_pkg::POS_W'(pfde_pkg::SIDE - 1);

  pfde_pkg::pos_t a_row;
  pfde_pkg::pos_t a_col;
  pfde_pkg::pos_t b_row;
  pfde_pkg::pos_t b_col;
  pfde_pkg::pos_t a_col_next;
  pfde_pkg::pos_t b_col_next;
  pfde_pkg::pos_t a_row_next;
  pfde_pkg::pos_t b_row_next;
  logic           miss;

  assign a_col_next = (loc_a.col == LAST) ? '0 : loc_a.col + 1'b1;
  assign b_col_next = (loc_b.col == LAST) ? '0 : loc_b.col + 1'b1;
  assign a_row_next = (loc_a.row == LAST) ? '0 : loc_a.row + 1'b1;
  assign b_row_next = (loc_b.row == LAST) ? '0 : loc_b.row + 1'b1;
  assign miss       = !loc_a.found || !loc_b.found;

  // Equal letters share a cell and therefore fall into the same-row rule.
  always_comb begin
    if (loc_a.row == loc_b.row) begin
      a_row = loc_a.row;
      a_col = a_col_next;
      b_row = loc_b.row;
      b_col = b_col_next;
    end else if (loc_a.col == loc_b.col) begin
      a_row = a_row_next;
      a_col = loc_a.col;
      b_row = b_row_next;
      b_col = loc_b.col;
    end else begin
      a_row = loc_a.row;
      a_col = loc_b.col;
      b_row = loc_b.row;
      b_col = loc_a.col;
    end
  end

  always_comb begin
    result.letter_missing = miss;
    result.cipher_first   = miss ? '0 : square[a_row][a_col];
    result.cipher_second  = miss ? '0 : square[b_row][b_col];
  end

endmodule

`default_nettype wire

// ===== rtl/playfair_digraph_encrypt_top.sv =====
// Top level of the Playfair digraph encryptor: key square registers, input
// register, result register and handshakes. Depends on pfde_pkg,
// pfde_locate and pfde_substitute.
//
//   Channel   Handshake             Payload
//   in        in_valid / in_stall   in_data   (first_letter, second_letter)
//   out       out_valid / out_stall out_data  (cipher_first, cipher_second,
//                                              letter_missing)
//   cfg       cfg_valid / cfg_ready cfg_index, cfg_data (one key square row)
//
// A request accepted into the input register moves to the result register when
// that is free and is offered as a valid result from there, so one request per
// cycle flows while the output does not stall. Reset clears both valid flags and
// all five key square rows. An output stall holds the result register while an
// empty input register still takes a request; in_stall rises only when both hold
// one. Configuration writes are always ready, and indexes past the last row are dropped.
`default_nettype none

module playfair_digraph_encrypt_top (
  input  var logic                               clk,
  input  var logic                               rst,
  input  var logic                               in_valid,
  output logic                                   in_stall,
  input  var pfde_pkg::in_t                      in_data,
  output logic                                   out_valid,
  input  var logic                               out_stall,
  output pfde_pkg::out_t                         out_data,
  input  var logic                               cfg_valid,
  output logic                                   cfg_ready,
  input  var logic [pfde_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  var logic [pfde_pkg::ROW_W-1:0]         cfg_data
);

  pfde_pkg::square_t square;
  logic              hold_valid;
  pfde_pkg::in_t     hold_data;
  pfde_pkg::loc_t    loc_a;
  pfde_pkg::loc_t    loc_b;
  pfde_pkg::out_t    result_next;
  logic              out_free;
  logic              advance;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign advance   = hold_valid && out_free;
  assign in_stall  = hold_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      square <= '0;
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index < pfde_pkg::CFG_IDX_W'(pfde_pkg::SIDE))) begin
      square[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_data <= in_data;
    end
  end

  pfde_locate u_locate_a (
    .square (square),
    .letter (hold_data.first_letter),
    .loc    (loc_a)
  );

  pfde_locate u_locate_b (
    .square (square),
    .letter (hold_data.second_letter),
    .loc    (loc_b)
  );

  pfde_substitute u_substitute (
    .square (square),
    .loc_a  (loc_a),
    .loc_b  (loc_b),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result_next;
    end
  end

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid && !hold_valid)
    else $error("pipeline not empty after reset");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> hold_valid && out_valid)
    else $error("input stalled with a free stage");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("request lost between input and result register");

  a_held_request_kept: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> hold_valid && $stable(hold_data))
    else $error("held request changed while stalled");

  a_missing_gives_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.letter_missing |->
      out_data.cipher_first == '0 && out_data.cipher_second == '0)
    else $error("ciphertext not zero for a missing letter");

endmodule

`default_nettype wire
